// ===== rtl/salc_pkg.sv =====
// Shared types and codes for the set-associative LRU cache simulator.
// No dependencies; imported by salc_ctrl, salc_dp and the top level.
package salc_pkg;

    localparam int ADDR_W     = 64;
    localparam int CMD_W      = 2;
    localparam int OUTC_W     = 2;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SETB_W     = 3;
    localparam int WAYS_W     = 4;
    localparam int BLKB_W     = 6;

    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd3;

    localparam logic [OUTC_W-1:0] OUTC_NONE  = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_MISS  = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [OUTC_W-1:0] outcome;
        logic              extra_hit;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  eviction_total;
    } rsp_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic read;
        logic look;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/salc_ctrl.sv =====
// Sequencer for the cache simulator: clearing pass, row read, lookup,
// victim scan and write-back. Depends on salc_pkg.
module salc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  salc_pkg::ctrl_status_t  status,
    output salc_pkg::ctrl_cmd_t     cmd
);
    import salc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_LOOK  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = status.need_scan ? S_SCAN : S_WRITE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/salc_dp.sv =====
// Datapath for the cache simulator: configuration, address split, set memory,
// hit/fill/victim selection, saturating totals and result register.
// Depends on salc_pkg; driven by salc_ctrl.
module salc_dp #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_BITS   = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  salc_pkg::ctrl_cmd_t                cmd,
    output salc_pkg::ctrl_status_t             status,
    input  salc_pkg::req_t                     req,
    input  logic                               cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output salc_pkg::rsp_t                     rsp
);
    import salc_pkg::*;

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS  = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int SE_W  = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
    localparam int TSH_W = 7;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] a);
        logic [CNT_W:0] sum;
        begin
            sum = {1'b0, v} + {{(CNT_W - 1){1'b0}}, a};
            sat_add = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
        end
    endfunction

    logic [SETB_W-1:0] set_bits_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic [BLKB_W-1:0] block_bits_reg;

    logic                  fetch_reg;
    logic                  extra_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_W-1:0]     tag_reg;
    logic [STAMP_BITS-1:0] clock_reg;
    logic [SET_W-1:0]      clear_addr_reg;

    logic [MAX_WAYS-1:0]                  mem_valid [ROWS];
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      mem_tag   [ROWS];
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  mem_stamp [ROWS];

    logic [MAX_WAYS-1:0]                  rd_valid_reg;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      rd_tag_reg;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  rd_stamp_reg;

    logic [WAY_W-1:0]      way_reg;
    logic [WAY_W-1:0]      scan_reg;
    logic [STAMP_BITS-1:0] min_reg;
    logic [OUTC_W-1:0]     outcome_reg;

    logic [CNT_W-1:0] hit_total_reg;
    logic [CNT_W-1:0] miss_total_reg;
    logic [CNT_W-1:0] evict_total_reg;
    logic [CNT_W-1:0] hit_total_next;
    logic [CNT_W-1:0] miss_total_next;
    logic [CNT_W-1:0] evict_total_next;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;

    logic [SE_W-1:0]   s_eff;
    logic [NW_W-1:0]   nw_eff;
    logic [ADDR_W-1:0] addr_shift;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  set_idx;
    logic [TSH_W-1:0]  tag_sh;
    logic [ADDR_W-1:0] tag_val;

    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic                hit_any;
    logic                inv_any;

    logic                                 row_we;
    logic [MAX_WAYS-1:0]                  wr_valid;
    logic [MAX_WAYS-1:0][ADDR_W-1:0]      wr_tag;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0]  wr_stamp;
    logic [1:0]                           hit_add;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= '0;
            ways_reg       <= WAYS_W'(1);
            block_bits_reg <= BLKB_W'(4);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[SETB_W-1:0];
                CFG_WAYS:       ways_reg       <= cfg_data[WAYS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLKB_W-1:0];
                default:        set_bits_reg   <= set_bits_reg;
            endcase
        end
    end

    // Address split
    always_comb
    begin
        s_eff = (32'(set_bits_reg) > MAX_SET_BITS) ? SE_W'(MAX_SET_BITS)
                                                   : SE_W'(set_bits_reg);
        if (ways_reg == '0)
        begin
            nw_eff = NW_W'(1);
        end
        else if (32'(ways_reg) > MAX_WAYS)
        begin
            nw_eff = NW_W'(MAX_WAYS);
        end
        else
        begin
            nw_eff = NW_W'(ways_reg);
        end
        addr_shift = req.address >> block_bits_reg;
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < int'(s_eff));
        end
        set_idx = addr_shift[SET_W-1:0] & set_mask;
        tag_sh  = TSH_W'(block_bits_reg) + TSH_W'(s_eff);
        tag_val = (tag_sh >= TSH_W'(ADDR_W)) ? '0 : (req.address >> tag_sh);
    end

    // Request capture and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg      <= '0;
            clear_addr_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                clock_reg <= clock_reg + STAMP_BITS'(1);
            end
            if (cmd.clear_step)
            begin
                clear_addr_reg <= clear_addr_reg + SET_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            fetch_reg <= (req.command == CMD_FETCH);
            extra_reg <= (req.command == CMD_MODIFY);
            set_reg   <= set_idx;
            tag_reg   <= tag_val;
        end
    end

    // Set memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem_valid[clear_addr_reg] <= '0;
            mem_tag[clear_addr_reg]   <= '0;
            mem_stamp[clear_addr_reg] <= '0;
        end
        else if (row_we)
        begin
            mem_valid[set_reg] <= wr_valid;
            mem_tag[set_reg]   <= wr_tag;
            mem_stamp[set_reg] <= wr_stamp;
        end
        if (cmd.read)
        begin
            rd_valid_reg <= mem_valid[set_reg];
            rd_tag_reg   <= mem_tag[set_reg];
            rd_stamp_reg <= mem_stamp[set_reg];
        end
    end

    // Lookup
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hit_vec[w] = (w < int'(nw_eff)) && rd_valid_reg[w] && (rd_tag_reg[w] == tag_reg);
            inv_vec[w] = (w < int'(nw_eff)) && !rd_valid_reg[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (inv_vec[w])
            begin
                inv_way = WAY_W'(w);
            end
        end
        hit_any = |hit_vec;
        inv_any = |inv_vec;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look)
        begin
            scan_reg <= WAY_W'(1);
            min_reg  <= rd_stamp_reg[0];
            if (fetch_reg)
            begin
                outcome_reg <= OUTC_NONE;
                way_reg     <= '0;
            end
            else if (hit_any)
            begin
                outcome_reg <= OUTC_HIT;
                way_reg     <= hit_way;
            end
            else if (inv_any)
            begin
                outcome_reg <= OUTC_MISS;
                way_reg     <= inv_way;
            end
            else
            begin
                outcome_reg <= OUTC_EVICT;
                way_reg     <= '0;
            end
        end
        else if (cmd.scan)
        begin
            scan_reg <= scan_reg + WAY_W'(1);
            if (rd_stamp_reg[scan_reg] < min_reg)
            begin
                way_reg <= scan_reg;
                min_reg <= rd_stamp_reg[scan_reg];
            end
        end
    end

    // Write-back row and totals
    always_comb
    begin
        row_we = cmd.commit && !fetch_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_W'(w) == way_reg)
            begin
                wr_valid[w] = 1'b1;
                wr_tag[w]   = tag_reg;
                wr_stamp[w] = clock_reg;
            end
            else
            begin
                wr_valid[w] = rd_valid_reg[w];
                wr_tag[w]   = rd_tag_reg[w];
                wr_stamp[w] = rd_stamp_reg[w];
            end
        end
        hit_add          = {1'b0, extra_reg} + {1'b0, (outcome_reg == OUTC_HIT)};
        hit_total_next   = sat_add(hit_total_reg, hit_add);
        miss_total_next  = sat_add(miss_total_reg,
                                   {1'b0, (outcome_reg == OUTC_MISS)
                                          || (outcome_reg == OUTC_EVICT)});
        evict_total_next = sat_add(evict_total_reg, {1'b0, (outcome_reg == OUTC_EVICT)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else if (cmd.commit)
        begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
            rsp_valid_reg   <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.outcome        <= outcome_reg;
            rsp_reg.extra_hit      <= extra_reg;
            rsp_reg.hit_total      <= hit_total_next;
            rsp_reg.miss_total     <= miss_total_next;
            rsp_reg.eviction_total <= evict_total_next;
        end
    end

    assign status.clear_done = (clear_addr_reg == SET_W'(ROWS - 1));
    assign status.need_scan  = !fetch_reg && !hit_any && !inv_any && (nw_eff != NW_W'(1));
    assign status.scan_done  = (NW_W'(scan_reg) == (nw_eff - NW_W'(1)));
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result committed while output register is held");

    a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (NW_W'(way_reg) < nw_eff))
        else $error("write-back to a way outside the active ways");

    a_fetch_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && fetch_reg) |=> (hit_total_reg == $past(hit_total_reg))
            && (miss_total_reg == $past(miss_total_reg))
            && (evict_total_reg == $past(evict_total_reg)))
        else $error("fetch changed a running total");

    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        evict_total_reg <= miss_total_reg)
        else $error("eviction total exceeds miss total");

endmodule

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// Top level of the set-associative LRU cache simulator.
// Instantiates salc_ctrl and salc_dp; depends on salc_pkg.
//
// One request (command and byte address) is handled at a time. A hit, a fill
// of a free way or a fetch goes through request capture, set row read, lookup
// and write-back before the next request is accepted. A miss on a full set
// adds a victim scan over the set row between lookup and write-back.
// The result sits in an output register, so the next request is
// taken while it waits; write-back holds only if that register is still
// full. After reset a clearing pass writes every set row once, with req_stall
// high; configuration writes are taken at any time (cfg_ready is always high)
// but belong between requests.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_BITS   = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  salc_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output salc_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import salc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_BITS   (STAMP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
